[src/baro_altitude_estimator_defines.svh]
// Assertion macros for the barometric altitude estimator RTL.
// Depends on nothing; included by bae_ctrl, which carries concurrent assertions.
`ifndef BARO_ALTITUDE_ESTIMATOR_DEFINES_SVH
`define BARO_ALTITUDE_ESTIMATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BAE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BAE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bae_pkg.sv]
// Package for the barometric altitude estimator: widths, constants, FSM type.
// No dependencies.
package bae_pkg;

    localparam int PRESS_W    = 21;
    localparam int TEMP_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int ALT_W      = 22;
    localparam int FILT_W     = 37;
    localparam int MANT_BITS  = 30;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 21;
    localparam int LOG_FRAC_BITS_DEF = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_GAIN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_REF_PRESS   = 1'b1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd6554;
    localparam logic [PRESS_W-1:0] REF_RESET   = 21'd1621200;
    localparam logic [20:0]        ALT_SCALE_K = 21'd1329702;
    localparam logic [15:0]        KELVIN_CENTI = 16'd27315;
    localparam logic [ALT_W-1:0]   ALT_LIMIT   = 22'd2000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_NORM,
        ST_SQ_F,
        ST_SQ_R,
        ST_DIFF,
        ST_MULT,
        ST_SCALE,
        ST_SAT,
        ST_OUT
    } bae_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_in;
        logic filt;
        logic norm;
        logic sq_step;
        logic diff;
        logic mult;
        logic scale;
        logic sat;
    } bae_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic enable;
        logic sq_done;
    } bae_stat_t;

endpackage

[src/baro_altitude_estimator.sv]
// Top level of the barometric altitude estimator.
// Depends on bae_pkg, bae_ctrl and bae_datapath.
//
// Usage: one item on s_axis (pressure, temperature, enable) produces one
// altitude item on m_axis. The block works on one item at a time: s_tready
// is high only while idle. An enabled item goes through the filter,
// normalization, the log2 unit that squares a mantissa once per fraction
// bit for the filtered and then the reference pressure, and the difference,
// multiply, scale and saturation states before m_tvalid; a disabled item
// goes from the filter straight to the output.
// The result holds on m_tdata until m_tready; the next item is taken the
// cycle after the result leaves. A stalled receiver simply stalls the block.
// Reset (aresetn low, synchronous) restores the gain and reference registers,
// clears the filter and its primed flag, and returns to idle.
// Configuration is written through cfg_we/cfg_addr/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module baro_altitude_estimator #(
    parameter int LOG_FRAC_BITS = bae_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [20:0] pressure_sample, [35:21] temperature_sample
    input  logic        s_tuser,   // [0] enable
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [21:0] altitude_cm
    input  logic        cfg_we,
    input  logic [bae_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bae_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bae_pkg::*;

    bae_cmd_t  cmd;
    bae_stat_t stat;
    logic signed [ALT_W-1:0] alt;

    bae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bae_datapath #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_data           (cfg_data),
        .pressure_sample    (s_tdata[20:0]),
        .temperature_sample (s_tdata[35:21]),
        .enable             (s_tuser),
        .altitude_cm        (alt)
    );

    assign m_tdata = {2'b00, alt};

endmodule

[src/bae_ctrl.sv]
// Controller FSM of the barometric altitude estimator.
// Depends on bae_pkg and the assertion macro header.
`include "baro_altitude_estimator_defines.svh"

module bae_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  bae_pkg::bae_stat_t stat,
    output bae_pkg::bae_cmd_t  cmd
);
    import bae_pkg::*;

    bae_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: squares run until the datapath reports the last fraction bit.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_FILT;
            ST_FILT:  state_next = stat.enable ? ST_NORM : ST_OUT;
            ST_NORM:  state_next = ST_SQ_F;
            ST_SQ_F:  state_next = ST_SQ_R;
            ST_SQ_R:  state_next = stat.sq_done ? ST_DIFF : ST_SQ_F;
            ST_DIFF:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_FILT:  cmd.filt = 1'b1;
            ST_NORM:  cmd.norm = 1'b1;
            ST_SQ_F:  cmd.sq_step = 1'b1;
            ST_SQ_R:  cmd.sq_step = 1'b1;
            ST_DIFF:  cmd.diff = 1'b1;
            ST_MULT:  cmd.mult = 1'b1;
            ST_SCALE: cmd.scale = 1'b1;
            ST_SAT:   cmd.sat = 1'b1;
            ST_OUT:   m_tvalid = 1'b1;
            default: begin
                cmd = '0;
            end
        endcase
    end

    `BAE_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid,
        "input and output handshakes open together")
    `BAE_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "controller took a second item while busy")
    `BAE_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid, "result dropped while stalled")

endmodule

[src/bae_datapath.sv]
// Datapath of the barometric altitude estimator: filter, shared log2 squarer,
// scaling and saturation. Depends on bae_pkg.
module bae_datapath #(
    parameter int LOG_FRAC_BITS = bae_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bae_pkg::bae_cmd_t             cmd,
    output bae_pkg::bae_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [bae_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bae_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [bae_pkg::PRESS_W-1:0]   pressure_sample,
    input  logic signed [bae_pkg::TEMP_W-1:0] temperature_sample,
    input  logic                          enable,
    output logic signed [bae_pkg::ALT_W-1:0] altitude_cm
);
    import bae_pkg::*;

    localparam int LW   = 6 + LOG_FRAC_BITS;      // log2 value width
    localparam int DW   = LW + 1;                 // signed difference
    localparam int AW   = DW + 17;                // signed product
    localparam int CW   = LOG_FRAC_BITS + 18;     // clamped magnitude
    localparam int CNTW = $clog2(LOG_FRAC_BITS + 1);
    localparam int SH   = LOG_FRAC_BITS + 16;

    logic [GAIN_W-1:0]  gain_reg;
    logic [PRESS_W-1:0] ref_reg;
    logic [FILT_W-1:0]  filt_reg;
    logic               primed_reg;
    logic [PRESS_W-1:0] p_reg;
    logic signed [TEMP_W-1:0] t_reg;
    logic               en_reg;
    logic [1:0]         spec_reg;   // 00 normal, 01 +lim, 10 -lim, 11 zero
    logic [MANT_BITS+1:0] mant_reg;
    logic [5:0]         exp_reg, exp_f_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_f_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               phase_reg;  // 0 squaring filtered, 1 squaring reference
    logic signed [DW-1:0] d_reg;
    logic signed [AW-1:0] a_reg;
    logic [CW-1:0]      mag_reg;
    logic [CW+21-SH:0]  scl_reg;
    logic signed [ALT_W-1:0] alt_val;
    logic [MANT_BITS+1:0] ref_mant_reg;
    logic [5:0]         ref_exp_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            ref_reg  <= REF_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_FILTER_GAIN) gain_reg <= cfg_data[GAIN_W-1:0];
            else ref_reg <= cfg_data;
        end
    end

    // Filter update: new = (w*(p<<16) + (65536-w)*f) >> 16; the first enabled sample loads p<<16.
    logic [FILT_W-1:0] ps;
    logic [16:0]       wold;
    logic [FILT_W+16:0] acc;
    logic [FILT_W-1:0] filt_next;
    always_comb begin
        ps   = {p_reg, 16'd0};
        wold = 17'd65536 - {1'b0, gain_reg};
        acc  = (FILT_W+17)'(ps) * (FILT_W+17)'(gain_reg)
             + (FILT_W+17)'(filt_reg) * (FILT_W+17)'(wold);
        filt_next = primed_reg ? acc[FILT_W+15:16] : ps;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg   <= '0;
            primed_reg <= 1'b0;
        end else if (cmd.filt && en_reg) begin
            filt_reg   <= filt_next;
            primed_reg <= 1'b1;
        end
    end

    // Input capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            p_reg  <= pressure_sample;
            t_reg  <= temperature_sample;
            en_reg <= enable;
        end
    end

    // Normalization to Q1.30 from the msb position.
    function automatic logic [5:0] msb_pos(input logic [FILT_W-1:0] x);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < FILT_W; i++) begin
            if (x[i]) r = 6'(i);
        end
        return r;
    endfunction

    function automatic logic [MANT_BITS+1:0] norm_mant(input logic [FILT_W-1:0] x,
                                                        input logic [5:0] e);
        logic [FILT_W+MANT_BITS-1:0] w;
        w = {{MANT_BITS{1'b0}}, x} << MANT_BITS;
        w = w >> e;
        return w[MANT_BITS+1:0];
    endfunction

    logic [FILT_W-1:0] ref_ext;
    assign ref_ext = {ref_reg, 16'd0};

    // Shared squarer step.
    logic [2*MANT_BITS+3:0] sq;
    logic [MANT_BITS+2:0]   sq_sh;
    logic                   sq_bit;
    logic [MANT_BITS+1:0]   mant_step;
    always_comb begin
        sq        = (2*MANT_BITS+4)'(mant_reg) * (2*MANT_BITS+4)'(mant_reg);
        sq_sh     = sq[2*MANT_BITS+2:MANT_BITS];
        sq_bit    = sq_sh[MANT_BITS+1];
        mant_step = sq_bit ? sq_sh[MANT_BITS+2:1] : sq_sh[MANT_BITS+1:0];
    end

    assign stat.sq_done = phase_reg && (cnt_reg == CNTW'(LOG_FRAC_BITS - 1));
    assign stat.enable  = en_reg;

    // Log sequencing: squares one mantissa per step, filtered first.
    always_ff @(posedge aclk) begin
        if (cmd.norm) begin
            exp_reg      <= msb_pos(filt_reg);
            mant_reg     <= norm_mant(filt_reg, msb_pos(filt_reg));
            ref_exp_reg  <= msb_pos(ref_ext);
            ref_mant_reg <= norm_mant(ref_ext, msb_pos(ref_ext));
            frac_reg     <= '0;
            cnt_reg      <= '0;
            phase_reg    <= 1'b0;
            if (filt_reg == '0 && ref_reg == '0) spec_reg <= 2'b11;
            else if (filt_reg == '0)             spec_reg <= 2'b01;
            else if (ref_reg == '0)              spec_reg <= 2'b10;
            else                                 spec_reg <= 2'b00;
        end else if (cmd.sq_step) begin
            if (cnt_reg == CNTW'(LOG_FRAC_BITS - 1) && !phase_reg) begin
                exp_f_reg  <= exp_reg;
                frac_f_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_bit};
                exp_reg    <= ref_exp_reg;
                mant_reg   <= ref_mant_reg;
                frac_reg   <= '0;
                cnt_reg    <= '0;
                phase_reg  <= 1'b1;
            end else begin
                mant_reg <= mant_step;
                frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq_bit};
                cnt_reg  <= cnt_reg + 1'b1;
            end
        end
    end

    // Difference, scaling by temperature, constant multiply, saturation.
    logic [LW-1:0] log_f, log_r;
    logic signed [17:0] tk;
    logic [AW-1:0] a_abs;
    assign log_f = {exp_f_reg, frac_f_reg};
    assign log_r = {exp_reg, frac_reg};
    assign tk    = 18'(t_reg) + $signed({2'b00, KELVIN_CENTI});
    assign a_abs = a_reg[AW-1] ? AW'(-a_reg) : AW'(a_reg);

    logic [CW+21:0] prod;
    assign prod = (CW+22)'(mag_reg) * (CW+22)'(ALT_SCALE_K)
                + ((CW+22)'(1) << (LOG_FRAC_BITS + 15));

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            d_reg <= $signed({1'b0, log_f}) - $signed({1'b0, log_r});
        end
        if (cmd.mult) begin
            a_reg <= AW'(d_reg) * AW'(tk);
        end
        if (cmd.scale) begin
            mag_reg <= (a_abs > AW'(1) << (LOG_FRAC_BITS + 17))
                     ? CW'(1) << (LOG_FRAC_BITS + 17) : a_abs[CW-1:0];
        end
        if (cmd.sat) begin
            scl_reg <= prod[CW+21:SH];
        end
    end

    // Output value; final limit and sign folded on the way out.
    logic [ALT_W-1:0] mag_lim;
    assign mag_lim = (scl_reg > (CW+22-SH)'(ALT_LIMIT)) ? ALT_LIMIT : scl_reg[ALT_W-1:0];

    always_comb begin
        priority if (!en_reg)            alt_val = '0;
        else if (spec_reg == 2'b11)      alt_val = '0;
        else if (spec_reg == 2'b01)      alt_val = ALT_LIMIT;
        else if (spec_reg == 2'b10)      alt_val = -ALT_LIMIT;
        else if (d_reg > 0)              alt_val = -$signed(mag_lim);
        else                             alt_val = $signed(mag_lim);
    end
    assign altitude_cm = alt_val;

endmodule
